[sv/ultrasonic_range_averager_assert.svh]
// ----------------------------------------------------------------------------
// Ultrasonic range averager assertion macros
// Concurrent checks, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef ULTRASONIC_RANGE_AVERAGER_ASSERT_SVH
`define ULTRASONIC_RANGE_AVERAGER_ASSERT_SVH

`ifndef SYNTHESIS
// Same-cycle implication
`define URA_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");
// Next-cycle implication
`define URA_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define URA_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define URA_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

[sv/ura_pkg.sv]
// ----------------------------------------------------------------------------
// Ultrasonic range averager package
// Field widths, register codes, reset values and shared types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ura_pkg;

  // Field widths
  localparam int ECHO_W    = 16;
  localparam int DIST_W    = 11;
  localparam int DIR_W     = 2;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 1;

  // Microseconds of echo per centimeter of range
  localparam int US_PER_CM = 58;
  localparam int DIVS_W    = $clog2(US_PER_CM + 1);

  // Direction codes; the reserved code behaves as no direction
  localparam logic [DIR_W-1:0] DIR_NONE = 2'd0;
  localparam logic [DIR_W-1:0] DIR_RSVD = 2'd3;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT = 1'b1;

  // Register reset values
  localparam logic [ECHO_W-1:0] TIMEOUT_RST = 16'd30000;
  localparam logic [DIST_W-1:0] DEFAULT_RST = 11'd120;

  // Commands from the sequencer to the sample window
  typedef struct packed {
    logic clear;
    logic push;
    logic sum_start;
  } win_cmd_t;

endpackage

[sv/ultrasonic_range_averager.sv]
// ----------------------------------------------------------------------------
// Ultrasonic range averager
// Converts echo widths to centimeters and averages a sliding sample window.
// ----------------------------------------------------------------------------
//
//   channel  handshake                    payload
//   -------  ---------------------------  ------------------------------
//   cfg      cfg_we_i                     cfg_idx_i, cfg_data_i
//   in       in_valid_i / in_stall_o      direction_i, echo_width_us_i
//   out      out_valid_o / out_stall_i    distance_cm_o
//
// A word with a direction makes two passes through the shared bit-serial
// divider, one quotient bit per cycle, and the serial window sum. With no
// direction the first divide is skipped; with an empty window, the second.
// Reset clears the window, the direction history and loads the register
// reset values. A stalled result sits in the output register while the next
// word is accepted and worked on.
`timescale 1ns / 1ps
`include "ultrasonic_range_averager_assert.svh"

module ultrasonic_range_averager
  import ura_pkg::*;
#(
  parameter int WINDOW_LEN = 3
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [DIR_W-1:0]     direction_i,
  input  logic [ECHO_W-1:0]    echo_width_us_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [DIST_W-1:0]    distance_cm_o
);

  localparam int SUM_W  = DIST_W + $clog2(WINDOW_LEN);
  localparam int FILL_W = $clog2(WINDOW_LEN + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV_CM,
    S_PUSH,
    S_SUM_GO,
    S_SUM_WAIT,
    S_DIV_AVG,
    S_RESULT
  } state_e;

  state_e            state_q;
  logic [ECHO_W-1:0] timeout_q;
  logic [DIST_W-1:0] default_q;
  logic [DIR_W-1:0]  prev_dir_q;
  logic [DIST_W-1:0] sample_q;
  logic [DIST_W-1:0] res_q;
  logic              out_valid_q;
  logic [DIST_W-1:0] out_q;

  logic              accept;
  logic [DIR_W-1:0]  dir_n;
  logic [ECHO_W-1:0] echo_eff;
  logic              div_start;
  logic [ECHO_W-1:0] div_dvd;
  logic [DIVS_W-1:0] div_dvs;
  logic              div_done;
  logic [ECHO_W-1:0] div_quot;
  win_cmd_t          win_cmd;
  logic [SUM_W-1:0]  win_sum;
  logic [FILL_W-1:0] win_fill;
  logic              sum_done;
  logic              out_free;

  assign accept   = in_valid_i && !in_stall_o;
  assign dir_n    = (direction_i == DIR_RSVD) ? DIR_NONE : direction_i;
  assign echo_eff = (echo_width_us_i == '0) ? timeout_q : echo_width_us_i;
  assign out_free = !out_valid_q || !out_stall_i;

  // Drive the divider and the window from the sequencer state
  always_comb begin
    win_cmd.clear     = accept && (dir_n != prev_dir_q);
    win_cmd.push      = (state_q == S_PUSH) && (sample_q != '0);
    win_cmd.sum_start = (state_q == S_SUM_GO);
    div_start         = 1'b0;
    div_dvd           = echo_eff;
    div_dvs           = DIVS_W'(US_PER_CM);
    if (accept && dir_n != DIR_NONE) begin
      div_start = 1'b1;
    end else if (state_q == S_SUM_WAIT && sum_done && win_fill != '0) begin
      div_start = 1'b1;
      div_dvd   = ECHO_W'(win_sum);
      div_dvs   = DIVS_W'(win_fill);
    end
  end

  // Hold configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= TIMEOUT_RST;
      default_q <= DEFAULT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_TIMEOUT: timeout_q <= cfg_data_i[ECHO_W-1:0];
        CFG_DEFAULT: default_q <= cfg_data_i[DIST_W-1:0];
      endcase
    end
  end

  // Sequence one word; hold the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      prev_dir_q  <= DIR_NONE;
      sample_q    <= '0;
      res_q       <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      if (out_valid_q && !out_stall_i && state_q != S_RESULT) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            prev_dir_q <= dir_n;
            if (dir_n == DIR_NONE) begin
              sample_q <= default_q;
              state_q  <= S_PUSH;
            end else begin
              state_q <= S_DIV_CM;
            end
          end
        end
        S_DIV_CM: begin
          if (div_done) begin
            sample_q <= div_quot[DIST_W-1:0];
            state_q  <= S_PUSH;
          end
        end
        S_PUSH:   state_q <= S_SUM_GO;
        S_SUM_GO: state_q <= S_SUM_WAIT;
        S_SUM_WAIT: begin
          if (sum_done) begin
            if (win_fill == '0) begin
              res_q   <= default_q;
              state_q <= S_RESULT;
            end else begin
              state_q <= S_DIV_AVG;
            end
          end
        end
        S_DIV_AVG: begin
          if (div_done) begin
            res_q   <= div_quot[DIST_W-1:0];
            state_q <= S_RESULT;
          end
        end
        S_RESULT: begin
          if (out_free) begin
            out_q       <= res_q;
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  ura_serial_div #(
    .DVD_W(ECHO_W),
    .DVS_W(DIVS_W)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(div_dvd),
    .divisor_i (div_dvs),
    .done_o    (div_done),
    .quotient_o(div_quot)
  );

  ura_sample_window #(
    .WINDOW_LEN(WINDOW_LEN)
  ) u_window (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (win_cmd),
    .sample_i  (sample_q),
    .sum_o     (win_sum),
    .fill_o    (win_fill),
    .sum_done_o(sum_done)
  );

  assign in_stall_o    = (state_q != S_IDLE);
  assign out_valid_o   = out_valid_q;
  assign distance_cm_o = out_q;

  `URA_ASSERT_NXT(a_top_accept_busy, clk_i, rst_ni, accept, in_stall_o)
  `URA_ASSERT_NXT(a_top_result_load, clk_i, rst_ni,
                  state_q == S_RESULT && !out_valid_q, out_valid_q && state_q == S_IDLE)
  `URA_ASSERT_IMP(a_top_idle_no_done, clk_i, rst_ni, state_q == S_IDLE, !div_done && !sum_done)

endmodule

[sv/ura_serial_div.sv]
// ----------------------------------------------------------------------------
// Ultrasonic range averager serial divider
// Restoring divider, one quotient bit per cycle, MSB first.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "ultrasonic_range_averager_assert.svh"

module ura_serial_div #(
  parameter int DVD_W = 16,
  parameter int DVS_W = 7
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DVD_W-1:0] dividend_i,
  input  logic [DVS_W-1:0] divisor_i,
  output logic             done_o,
  output logic [DVD_W-1:0] quotient_o
);

  localparam int CNT_W = $clog2(DVD_W);

  logic [DVD_W-1:0] shift_q, shift_d;
  logic [DVS_W-1:0] rem_q, rem_d;
  logic [DVS_W-1:0] dvs_q;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q;
  logic             done_q;
  logic [DVS_W:0]   trial;
  logic [DVS_W+1:0] diff;
  logic             qbit;

  // Bring down the next dividend bit and try one subtract
  always_comb begin
    trial   = {rem_q, shift_q[DVD_W-1]};
    diff    = {1'b0, trial} - {2'b00, dvs_q};
    qbit    = ~diff[DVS_W+1];
    rem_d   = qbit ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
    shift_d = {shift_q[DVD_W-2:0], qbit};
  end

  // Hold the dividend, shift in quotient bits, count steps
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(DVD_W - 1);
      end else if (busy_q) begin
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      shift_q <= dividend_i;
      rem_q   <= '0;
      dvs_q   <= divisor_i;
    end else if (busy_q) begin
      shift_q <= shift_d;
      rem_q   <= rem_d;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = shift_q;

  `URA_ASSERT_IMP(a_div_no_restart, clk_i, rst_ni, start_i, !busy_q)
  `URA_ASSERT_NXT(a_div_last_step_done, clk_i, rst_ni, busy_q && cnt_q == '0, done_q)
  `URA_ASSERT_IMP(a_div_done_idle, clk_i, rst_ni, done_q, !busy_q)

endmodule

[sv/ura_sample_window.sv]
// ----------------------------------------------------------------------------
// Ultrasonic range averager sample window
// Sliding window of distance samples with a serial sum, one entry per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "ultrasonic_range_averager_assert.svh"

module ura_sample_window
  import ura_pkg::*;
#(
  parameter int WINDOW_LEN = 3
) (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  input  win_cmd_t                                    cmd_i,
  input  logic [DIST_W-1:0]                           sample_i,
  output logic [DIST_W+$clog2(WINDOW_LEN)-1:0]        sum_o,
  output logic [$clog2(WINDOW_LEN+1)-1:0]             fill_o,
  output logic                                        sum_done_o
);

  localparam int SLOT_W = $clog2(WINDOW_LEN);
  localparam int FILL_W = $clog2(WINDOW_LEN + 1);
  localparam int SUM_W  = DIST_W + $clog2(WINDOW_LEN);
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(WINDOW_LEN - 1);
  localparam logic [FILL_W-1:0] FULL      = FILL_W'(WINDOW_LEN);

  logic [DIST_W-1:0] win_q [WINDOW_LEN];
  logic [SLOT_W-1:0] slot_q;
  logic [FILL_W-1:0] fill_q;
  logic [SLOT_W-1:0] idx_q;
  logic [SUM_W-1:0]  acc_q, acc_d;
  logic              busy_q;
  logic              done_q;

  // Add the selected entry to the running sum
  assign acc_d = acc_q + SUM_W'(win_q[idx_q]);

  // Clear or push samples; advance the write slot and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < WINDOW_LEN; i++) begin
        win_q[i] <= '0;
      end
      slot_q <= '0;
      fill_q <= '0;
    end else if (cmd_i.clear) begin
      for (int i = 0; i < WINDOW_LEN; i++) begin
        win_q[i] <= '0;
      end
      slot_q <= '0;
      fill_q <= '0;
    end else if (cmd_i.push) begin
      win_q[slot_q] <= sample_i;
      slot_q        <= (slot_q == LAST_SLOT) ? '0 : slot_q + 1'b1;
      if (fill_q != FULL) begin
        fill_q <= fill_q + 1'b1;
      end
    end
  end

  // Walk the entries one per cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      idx_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (cmd_i.sum_start) begin
        busy_q <= 1'b1;
        idx_q  <= '0;
      end else if (busy_q) begin
        if (idx_q == LAST_SLOT) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          idx_q <= idx_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.sum_start) begin
      acc_q <= '0;
    end else if (busy_q) begin
      acc_q <= acc_d;
    end
  end

  assign sum_o      = acc_q;
  assign fill_o     = fill_q;
  assign sum_done_o = done_q;

  `URA_ASSERT_IMP(a_win_fill_bound, clk_i, rst_ni, 1'b1, fill_q <= FULL)
  `URA_ASSERT_IMP(a_win_slot_bound, clk_i, rst_ni, 1'b1, slot_q <= LAST_SLOT)
  `URA_ASSERT_NXT(a_win_first_push, clk_i, rst_ni,
                  cmd_i.push && !cmd_i.clear && fill_q == '0, fill_q == FILL_W'(1))

endmodule

[tb/ultrasonic_range_averager_test.sv]
// ----------------------------------------------------------------------------
// Ultrasonic range averager testbench
// Drives direction and echo words through the valid/stall channels, with
// random idle bursts on both sides. A short directed table with its own
// expected distances covers the edge cases; random runs of words, checked
// against a cycle-free window model, use several register settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ultrasonic_range_averager_test;
  import ura_pkg::*;

  localparam int WIN           = 3;
  localparam int SETTLE_CYCLES = 64;
  localparam int PHASE_WORDS   = 65;
  localparam int NUM_PHASES    = 6;

  // Sensor directions not named in the package
  localparam logic [DIR_W-1:0] DIR_FWD = 2'd1;
  localparam logic [DIR_W-1:0] DIR_REV = 2'd2;

  typedef struct packed {
    logic [DIR_W-1:0]  dir;
    logic [ECHO_W-1:0] echo;
    logic              typed;
    logic [DIST_W-1:0] want;
  } echo_row_t;

  // Directed words, starting from reset (timeout 30000 us, default 120 cm)
  localparam echo_row_t SCRIPT [16] = '{
    '{DIR_NONE, 16'hFFFF, 1'b1, 11'd120},  // echo ignored with no direction
    '{DIR_RSVD, 16'h0000, 1'b1, 11'd120},  // reserved code acts as none
    '{DIR_FWD,  16'h0000, 1'b1, 11'd517},  // timeout echo after a clear
    '{DIR_FWD,  16'hFFFF, 1'b0, 11'd0},    // widest echo
    '{DIR_FWD,  16'd57,   1'b0, 11'd0},    // zero sample, not stored
    '{DIR_FWD,  16'd58,   1'b0, 11'd0},    // smallest stored sample
    '{DIR_FWD,  16'h5555, 1'b0, 11'd0},    // window wraps
    '{DIR_FWD,  16'hAAAA, 1'b0, 11'd0},
    '{DIR_REV,  16'd57,   1'b1, 11'd120},  // clear, empty window
    '{DIR_REV,  16'd1,    1'b1, 11'd120},
    '{DIR_REV,  16'h8000, 1'b0, 11'd0},
    '{DIR_REV,  16'h7FFF, 1'b0, 11'd0},
    '{DIR_REV,  16'h0000, 1'b0, 11'd0},
    '{DIR_RSVD, 16'hFFFF, 1'b1, 11'd120},  // clear on change to none
    '{DIR_FWD,  16'h0001, 1'b1, 11'd120},  // clear, zero sample
    '{DIR_NONE, 16'h0000, 1'b1, 11'd120}
  };

  logic                 clk           = 1'b0;
  logic                 rst_n         = 1'b0;
  logic                 cfg_we        = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx       = CFG_TIMEOUT;
  logic [CFG_W-1:0]     cfg_data      = '0;
  logic                 in_valid      = 1'b0;
  logic                 in_stall;
  logic [DIR_W-1:0]     direction     = DIR_NONE;
  logic [ECHO_W-1:0]    echo_width_us = '0;
  logic                 out_valid;
  logic                 out_stall     = 1'b0;
  logic [DIST_W-1:0]    distance_cm;

  // Model state: window, registers and direction history
  logic [DIST_W-1:0] win_samples [WIN];
  int unsigned       win_slot;
  int unsigned       win_fill;
  logic [DIR_W-1:0]  held_dir;
  logic [ECHO_W-1:0] cur_timeout;
  logic [DIST_W-1:0] cur_default;

  logic [DIST_W-1:0] expected_distances [$];
  bit                calm;
  int                errors;
  int                words_sent;
  int                distances_checked;
  int                settings_used;

  ultrasonic_range_averager dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_data_i      (cfg_data),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .direction_i     (direction),
    .echo_width_us_i (echo_width_us),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .distance_cm_o   (distance_cm)
  );

  always #5 clk = ~clk;

  // Hold reset asserted at start-up, then release it for good
  initial begin
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
  end

  // Stop a hung run
  initial begin
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // Reset the model to the block's reset state
  task automatic reset_model();
    for (int i = 0; i < WIN; i++) win_samples[i] = '0;
    win_slot    = 0;
    win_fill    = 0;
    held_dir    = DIR_NONE;
    cur_timeout = TIMEOUT_RST;
    cur_default = DEFAULT_RST;
  endtask

  // Advance the averaging window by one word and return the mean distance
  function automatic logic [DIST_W-1:0] predict_distance(
    input logic [DIR_W-1:0]  dir,
    input logic [ECHO_W-1:0] echo
  );
    logic [DIR_W-1:0]  eff_dir;
    logic [ECHO_W-1:0] width;
    logic [ECHO_W-1:0] cm;
    logic [DIST_W+1:0] total;
    eff_dir = (dir == DIR_RSVD) ? DIR_NONE : dir;
    if (eff_dir != held_dir) begin
      for (int i = 0; i < WIN; i++) win_samples[i] = '0;
      win_slot = 0;
      win_fill = 0;
      held_dir = eff_dir;
    end
    if (eff_dir == DIR_NONE) begin
      cm = ECHO_W'(cur_default);
    end else begin
      width = (echo == '0) ? cur_timeout : echo;
      cm    = ECHO_W'(width / US_PER_CM);
    end
    // Store only nonzero samples; the oldest entry goes when full
    if (cm != '0) begin
      win_samples[win_slot] = cm[DIST_W-1:0];
      win_slot = (win_slot + 1 >= WIN) ? 0 : win_slot + 1;
      if (win_fill < WIN) win_fill++;
    end
    if (win_fill == 0) return cur_default;
    total = '0;
    for (int i = 0; i < WIN; i++) total += win_samples[i];
    return DIST_W'(total / win_fill);
  endfunction

  // Write one register while the block is idle
  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_W-1:0] data);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_TIMEOUT) cur_timeout = data;
    else cur_default = data[DIST_W-1:0];
  endtask

  // Offer one word after an optional gap and hold it until accepted
  task automatic send_word(input logic [DIR_W-1:0] dir,
                           input logic [ECHO_W-1:0] echo,
                           input bit typed,
                           input logic [DIST_W-1:0] want);
    int               gap;
    logic [DIST_W-1:0] predicted;
    gap = (!calm && $urandom_range(0, 3) == 0) ? $urandom_range(1, 18) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid      <= 1'b1;
    direction     <= dir;
    echo_width_us <= echo;
    do @(posedge clk); while (in_stall);
    predicted = predict_distance(dir, echo);
    expected_distances.push_back(typed ? want : predicted);
    words_sent++;
  endtask

  // Drop valid and wait until every expected distance has come back
  task automatic drain_and_settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_distances.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Random result stall: bursts of stall between free stretches
  initial begin
    @(negedge clk);
    forever begin
      if (!calm && $urandom_range(0, 2) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 18)) @(negedge clk);
      end
      out_stall <= 1'b0;
      repeat ($urandom_range(1, 18)) @(negedge clk);
    end
  end

  // Check each accepted distance against the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_distances.size() == 0) begin
        $error("distance_cm: no word pending, actual %0d", distance_cm);
        errors++;
      end else begin
        if (distance_cm !== expected_distances[0]) begin
          $error("distance_cm: expected %0d, actual %0d",
                 expected_distances[0], distance_cm);
          errors++;
        end
        void'(expected_distances.pop_front());
        distances_checked++;
      end
    end
  end

  initial begin
    logic [DIR_W-1:0]  run_dir;
    logic [ECHO_W-1:0] echo;
    logic [CFG_W-1:0]  tmo_val;
    logic [CFG_W-1:0]  dflt_val;
    int                run_len;
    int                sent;
    int                pick;
    errors            = 0;
    words_sent        = 0;
    distances_checked = 0;
    settings_used     = 1;
    calm              = 1'b0;
    reset_model();
    @(posedge rst_n);

    // Walk the directed table at reset register values
    foreach (SCRIPT[i])
      send_word(SCRIPT[i].dir, SCRIPT[i].echo, SCRIPT[i].typed, SCRIPT[i].want);

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      drain_and_settle();
      case (ph)
        0: begin tmo_val = 16'd58;    dflt_val = 16'd1;    end
        1: begin tmo_val = 16'hFFFF;  dflt_val = 16'd1129; end
        2: begin tmo_val = 16'd57;    dflt_val = 16'd0;    end
        3: begin tmo_val = 16'd0;     dflt_val = 16'hFFFF; end
        4: begin
          tmo_val  = CFG_W'($urandom_range(58, 65535));
          dflt_val = CFG_W'($urandom_range(1, 1129));
        end
        default: begin tmo_val = 16'd30000; dflt_val = 16'd120; end
      endcase
      write_register(CFG_TIMEOUT, tmo_val);
      write_register(CFG_DEFAULT, dflt_val);
      settings_used++;
      // Run the last setting with no idling on either side
      if (ph == NUM_PHASES - 1) calm = 1'b1;

      sent = 0;
      while (sent < PHASE_WORDS) begin
        // Mostly runs on one sensor, so the window fills and wraps
        pick = $urandom_range(0, 9);
        if (pick < 4) run_dir = DIR_FWD;
        else if (pick < 7) run_dir = DIR_REV;
        else if (pick < 9) run_dir = DIR_NONE;
        else run_dir = DIR_RSVD;
        run_len = $urandom_range(1, 8);
        for (int k = 0; k < run_len && sent < PHASE_WORDS; k++) begin
          pick = $urandom_range(0, 15);
          if (pick < 2) echo = '0;
          else if (pick == 2) echo = ECHO_W'($urandom_range(1, 57));
          else if (pick == 3) echo = 16'hFFFF;
          else if (pick < 10) echo = ECHO_W'($urandom_range(58, 23200));
          else echo = ECHO_W'($urandom);
          send_word(run_dir, echo, 1'b0, '0);
          sent++;
        end
      end
    end

    // Let the last distances come back and the block settle
    drain_and_settle();
    $display("Sent %0d words under %0d register settings; checked %0d distances.",
             words_sent, settings_used, distances_checked);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
